[rtl/tpz_pkg.sv]
// Shared types, constants and the glyph lookup for the torus point z-buffer shader.
// No dependencies; every other file in rtl/ except tpz_ram imports this package.
package tpz_pkg;

    localparam int VAL_W      = 20;
    typedef logic signed [VAL_W-1:0] val_t;

    localparam int Q_FRAC     = 14;
    localparam int Q_ONE      = 16384;

    // Quarter-wave sine polynomial coefficients, Q14.
    localparam int SINE_C1    = 25736;
    localparam int SINE_C2    = 10512;
    localparam int SINE_C3    = 1160;

    localparam int TUBE_OFFSET  = 2;
    localparam int DEPTH_OFFSET = 5;
    localparam int X_CENTER   = 40;
    localparam int X_SCALE    = 30;
    localparam int Y_CENTER   = 12;
    localparam int Y_SCALE    = 15;

    // Luminance times eight over Q_ONE is a right shift by eleven.
    localparam int LUM_SHIFT  = 11;

    localparam int OUT_DATA_W = 8;
    localparam int CHAR_W     = 7;
    localparam logic [CHAR_W-1:0] CHAR_SPACE = 7'd32;
    localparam logic [CHAR_W-1:0] CHAR_LAST  = 7'd126;

    localparam int GLYPH_W    = 4;
    typedef logic [GLYPH_W-1:0] glyph_t;
    localparam glyph_t GLYPH_MAX  = 4'd11;
    localparam glyph_t BLANK_CODE = 4'd12;

    localparam logic REQ_PLOT  = 1'b0;
    localparam logic REQ_READ  = 1'b1;
    localparam logic CFG_ROT_A = 1'b0;
    localparam logic CFG_ROT_B = 1'b1;

    function automatic logic [CHAR_W-1:0] glyph_char(input glyph_t code);
        logic [CHAR_W-1:0] c;
        case (code)
            4'd0:    c = 7'h2E; // .
            4'd1:    c = 7'h2C; // ,
            4'd2:    c = 7'h2D; // -
            4'd3:    c = 7'h7E; // ~
            4'd4:    c = 7'h3A; // :
            4'd5:    c = 7'h3B; // ;
            4'd6:    c = 7'h3D; // =
            4'd7:    c = 7'h21; // !
            4'd8:    c = 7'h2A; // *
            4'd9:    c = 7'h23; // #
            4'd10:   c = 7'h24; // $
            4'd11:   c = 7'h40; // @
            default: c = CHAR_SPACE;
        endcase
        return c;
    endfunction

endpackage

[rtl/torus_point_zbuffer_shader.sv]
// Plot item: eight sines and then eighteen products on the one shared multiplier; the
// 31-step reciprocal divider runs alongside, and the sequencer waits for its quotient.
// Read item: an address outside the grid skips the cell store. One item at a time; a
// finished result waits in an output register.
// Reset (synchronous, active low) starts a clearing pass over all GRID_COLS*GRID_ROWS
// cells (1760 by default) of the cell store, during which no item is taken.
module torus_point_zbuffer_shader #(
    parameter int  GRID_COLS  = 80,
    parameter int  GRID_ROWS  = 22,
    parameter int  ANGLE_BITS = 12,
    parameter int  DEPTH_BITS = 16,
    localparam int CELL_COUNT = GRID_COLS * GRID_ROWS,
    localparam int ADDR_W     = $clog2(CELL_COUNT),
    localparam int IN_DATA_W  = ((2*ANGLE_BITS + ADDR_W + 7) / 8) * 8
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [IN_DATA_W-1:0]            s_tdata,  // theta, phi, cell_addr, zero pad
    input  logic                            s_tuser,  // req_type
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [tpz_pkg::OUT_DATA_W-1:0]  m_tdata,  // cell_char, zero pad
    output logic                            m_tuser,  // plotted
    input  logic                            cfg_we,
    input  logic [0:0]                      cfg_addr,
    input  logic [ANGLE_BITS-1:0]           cfg_wdata
);
    import tpz_pkg::*;

    localparam int MW   = (DEPTH_BITS + 1 > VAL_W) ? DEPTH_BITS + 1 : VAL_W;
    localparam int PW   = 2 * MW;
    localparam int K    = DEPTH_BITS + Q_FRAC;
    localparam int SW   = PW + 8;
    localparam int RAMW = GLYPH_W + DEPTH_BITS;

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_SINE  = 3'd2;
    localparam logic [2:0] ST_MAIN  = 3'd3;
    localparam logic [2:0] ST_PLACE = 3'd4;
    localparam logic [2:0] ST_FETCH = 3'd5;
    localparam logic [2:0] ST_TEST  = 3'd6;
    localparam logic [2:0] ST_OUT   = 3'd7;

    localparam logic [4:0] STEP_DEN  = 5'd2;
    localparam logic [4:0] STEP_RAWX = 5'd16;
    localparam logic [4:0] STEP_LAST = 5'd17;
    localparam logic [2:0] SINE_LAST = 3'd7;
    localparam logic [1:0] SUB_LAST  = 2'd3;

    logic [2:0]            state_reg, state_next;
    logic [4:0]            step_reg, step_next;
    logic                  phase_reg, phase_next;
    logic [2:0]            sin_k_reg, sin_k_next;
    logic [1:0]            sub_reg, sub_next;
    logic [ADDR_W-1:0]     clr_reg, clr_next;
    logic                  m_tvalid_reg, m_tvalid_next;

    logic [ANGLE_BITS-1:0] rot_a_reg, rot_b_reg, theta_reg, phi_reg;
    logic [ADDR_W-1:0]     addr_reg;
    logic                  is_read_reg;
    logic [CHAR_W-1:0]     res_char_reg, out_char_reg;
    logic                  res_plot_reg, out_plot_reg;
    glyph_t                n_reg;

    val_t sv_reg [8];
    val_t u2_reg, t_reg, h_reg, ch_reg, acc_reg, msc_reg, mss_reg, tt_reg;
    val_t lh_reg, bx_reg, by_reg, cd_reg, cc_reg, lum_reg;
    logic signed [15:0] xs_reg, ys_reg;

    logic [ADDR_W-1:0]     in_addr;
    logic                  in_addr_ok;
    logic                  in_grid;
    logic [31:0]           off_c;

    logic [ANGLE_BITS-1:0] ang_c;
    logic [15:0]           phase_c;
    logic [14:0]           uu_c;
    val_t                  opa, opb;
    logic signed [MW-1:0]  mul_a, mul_b;
    logic signed [PW-1:0]  mul_prod;
    logic signed [PW-Q_FRAC-1:0] mul_q;
    val_t                  mq;
    val_t                  den_c;
    logic [VAL_W-1:0]      den_u;
    logic                  div_start, div_done;
    logic [DEPTH_BITS-1:0] d_q;
    logic signed [SW-1:0]  pw_c, sum_c;
    logic signed [15:0]    pos_c;
    glyph_t                glyph_c;

    logic                  ram_we;
    logic [ADDR_W-1:0]     ram_waddr;
    logic [RAMW-1:0]       ram_wdata, ram_rdata;
    logic [DEPTH_BITS-1:0] rd_depth;
    glyph_t                rd_glyph;

    assign in_addr    = s_tdata[2*ANGLE_BITS +: ADDR_W];
    assign in_addr_ok = (32'(in_addr) < 32'(CELL_COUNT));
    assign s_tready   = (state_reg == ST_IDLE);
    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = {1'b0, out_char_reg};
    assign m_tuser    = out_plot_reg;

    // Angle for the current sine: odd entries add a quarter turn for the cosine.
    always_comb begin
        case (sin_k_reg[2:1])
            2'd0:    ang_c = theta_reg;
            2'd1:    ang_c = phi_reg;
            2'd2:    ang_c = rot_a_reg;
            default: ang_c = rot_b_reg;
        endcase
        if (sin_k_reg[0]) begin
            ang_c = ang_c + ANGLE_BITS'(1 << (ANGLE_BITS - 2));
        end
        phase_c = 16'(32'(ang_c) << (16 - ANGLE_BITS));
        uu_c    = phase_c[14] ? 15'(15'd16384 - {1'b0, phase_c[13:0]}) : {1'b0, phase_c[13:0]};
    end

    // Operand selection for the shared multiplier.
    always_comb begin
        opa   = '0;
        opb   = '0;
        mul_a = '0;
        mul_b = '0;
        if (state_reg == ST_SINE) begin
            case (sub_reg)
                2'd0:    begin opa = val_t'(uu_c);            opb = val_t'(uu_c); end
                2'd1:    begin opa = val_t'(SINE_C3);         opb = u2_reg;       end
                2'd2:    begin opa = val_t'(SINE_C2) - t_reg; opb = u2_reg;       end
                default: begin opa = val_t'(SINE_C1) - t_reg; opb = val_t'(uu_c); end
            endcase
        end else begin
            case (step_reg)
                5'd0:    begin opa = sv_reg[0]; opb = h_reg;     end
                5'd1:    begin opa = ch_reg;    opb = sv_reg[4]; end
                5'd2:    begin opa = sv_reg[2]; opb = sv_reg[5]; end
                5'd3:    begin opa = ch_reg;    opb = sv_reg[5]; end
                5'd4:    begin opa = sv_reg[2]; opb = sv_reg[4]; end
                5'd5:    begin opa = sv_reg[1]; opb = h_reg;     end
                5'd6:    begin opa = lh_reg;    opb = sv_reg[7]; end
                5'd7:    begin opa = tt_reg;    opb = sv_reg[6]; end
                5'd8:    begin opa = lh_reg;    opb = sv_reg[6]; end
                5'd9:    begin opa = tt_reg;    opb = sv_reg[7]; end
                5'd10:   begin opa = sv_reg[0]; opb = sv_reg[3]; end
                5'd11:   begin opa = cd_reg;    opb = sv_reg[5]; end
                5'd12:   begin opa = acc_reg;   opb = sv_reg[7]; end
                5'd13:   begin opa = cd_reg;    opb = sv_reg[4]; end
                5'd14:   begin opa = sv_reg[1]; opb = sv_reg[3]; end
                5'd15:   begin opa = cc_reg;    opb = sv_reg[6]; end
                5'd16:   begin opa = '0;        opb = bx_reg;    end
                default: begin opa = '0;        opb = by_reg;    end
            endcase
        end
        mul_a = MW'(opa);
        mul_b = MW'(opb);
        if (state_reg == ST_MAIN && step_reg >= STEP_RAWX) begin
            mul_a = MW'({1'b0, d_q});
        end
    end

    tpz_mul #(.WIDTH(MW)) u_mul (
        .aclk   (aclk),
        .op_a   (mul_a),
        .op_b   (mul_b),
        .prod   (mul_prod),
        .prod_q (mul_q)
    );

    assign mq = mul_q[VAL_W-1:0];

    always_comb begin
        den_c     = acc_reg + mq + val_t'(DEPTH_OFFSET * Q_ONE);
        den_u     = (den_c < val_t'(1)) ? VAL_W'(1) : den_c;
        div_start = (state_reg == ST_MAIN) && phase_reg && (step_reg == STEP_DEN);
    end

    tpz_div #(.DEPTH_BITS(DEPTH_BITS), .DEN_W(VAL_W)) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .den     (den_u),
        .done    (div_done),
        .quo     (d_q)
    );

    // Screen position: centre plus scale times D times the coordinate, over 2^K.
    always_comb begin
        pw_c = SW'(mul_prod);
        if (step_reg == STEP_RAWX) begin
            sum_c = (SW'(X_CENTER) <<< K) + pw_c * SW'(X_SCALE);
        end else begin
            sum_c = (SW'(Y_CENTER) <<< K) + pw_c * SW'(Y_SCALE);
        end
        pos_c = 16'(sum_c >>> K);
    end

    always_comb begin
        in_grid = (xs_reg > 0) && (xs_reg < GRID_COLS) && (ys_reg > 0) && (ys_reg < GRID_ROWS);
        off_c   = 32'(ys_reg) * 32'(GRID_COLS) + 32'(xs_reg);
        if (lum_reg < 0) begin
            glyph_c = '0;
        end else if ((lum_reg >>> LUM_SHIFT) > val_t'(GLYPH_MAX)) begin
            glyph_c = GLYPH_MAX;
        end else begin
            glyph_c = GLYPH_W'(lum_reg >>> LUM_SHIFT);
        end
    end

    // Sequencer.
    always_comb begin
        state_next    = state_reg;
        step_next     = step_reg;
        phase_next    = phase_reg;
        sin_k_next    = sin_k_reg;
        sub_next      = sub_reg;
        clr_next      = clr_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        case (state_reg)
            ST_CLEAR: begin
                clr_next = clr_reg + 1'b1;
                if (clr_reg == ADDR_W'(CELL_COUNT - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    if (s_tuser == REQ_READ) begin
                        state_next = in_addr_ok ? ST_FETCH : ST_OUT;
                    end else begin
                        state_next = ST_SINE;
                        sin_k_next = '0;
                        sub_next   = '0;
                        phase_next = 1'b0;
                    end
                end
            end
            ST_SINE: begin
                phase_next = !phase_reg;
                if (phase_reg) begin
                    sub_next = sub_reg + 1'b1;
                    if (sub_reg == SUB_LAST) begin
                        sin_k_next = sin_k_reg + 1'b1;
                        if (sin_k_reg == SINE_LAST) begin
                            state_next = ST_MAIN;
                            step_next  = '0;
                        end
                    end
                end
            end
            ST_MAIN: begin
                if (!phase_reg) begin
                    if (!(step_reg == STEP_RAWX && !div_done)) begin
                        phase_next = 1'b1;
                    end
                end else begin
                    phase_next = 1'b0;
                    step_next  = step_reg + 1'b1;
                    if (step_reg == STEP_LAST) begin
                        state_next = ST_PLACE;
                    end
                end
            end
            ST_PLACE: state_next = in_grid ? ST_FETCH : ST_OUT;
            ST_FETCH: state_next = ST_TEST;
            ST_TEST:  state_next = ST_OUT;
            ST_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            step_reg     <= '0;
            phase_reg    <= 1'b0;
            sin_k_reg    <= '0;
            sub_reg      <= '0;
            clr_reg      <= '0;
            m_tvalid_reg <= 1'b0;
            rot_a_reg    <= '0;
            rot_b_reg    <= '0;
        end else begin
            state_reg    <= state_next;
            step_reg     <= step_next;
            phase_reg    <= phase_next;
            sin_k_reg    <= sin_k_next;
            sub_reg      <= sub_next;
            clr_reg      <= clr_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_we) begin
                case (cfg_addr)
                    CFG_ROT_A: rot_a_reg <= cfg_wdata;
                    CFG_ROT_B: rot_b_reg <= cfg_wdata;
                    default:   ;
                endcase
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            theta_reg    <= s_tdata[ANGLE_BITS-1:0];
            phi_reg      <= s_tdata[2*ANGLE_BITS-1:ANGLE_BITS];
            addr_reg     <= in_addr;
            is_read_reg  <= s_tuser;
            res_char_reg <= CHAR_SPACE;
            res_plot_reg <= 1'b0;
        end
        if (state_reg == ST_SINE && phase_reg) begin
            case (sub_reg)
                2'd0:    u2_reg <= mq;
                2'd1:    t_reg  <= mq;
                2'd2:    t_reg  <= mq;
                default: begin
                    sv_reg[sin_k_reg] <= phase_c[15] ? -mq : mq;
                    // The tube radius term follows the cosine of phi.
                    if (sin_k_reg == 3'd3) begin
                        h_reg <= (phase_c[15] ? -mq : mq) + val_t'(TUBE_OFFSET * Q_ONE);
                    end
                end
            endcase
        end
        if (state_reg == ST_MAIN && phase_reg) begin
            case (step_reg)
                5'd0:    ch_reg  <= mq;
                5'd1:    acc_reg <= mq;
                5'd2:    msc_reg <= mq;
                5'd3:    tt_reg  <= mq;
                5'd4:    begin mss_reg <= mq; tt_reg <= tt_reg - mq; end
                5'd5:    lh_reg  <= mq;
                5'd6:    bx_reg  <= mq;
                5'd7:    bx_reg  <= bx_reg - mq;
                5'd8:    by_reg  <= mq;
                5'd9:    by_reg  <= by_reg + mq;
                5'd10:   cd_reg  <= mq;
                5'd11:   acc_reg <= mss_reg - mq;
                5'd12:   lum_reg <= mq;
                5'd13:   lum_reg <= lum_reg - mq - msc_reg;
                5'd14:   cc_reg  <= mq;
                5'd15:   lum_reg <= lum_reg - mq;
                5'd16:   xs_reg  <= pos_c;
                default: ys_reg  <= pos_c;
            endcase
        end
        if (state_reg == ST_PLACE) begin
            addr_reg <= off_c[ADDR_W-1:0];
            n_reg    <= glyph_c;
        end
        if (state_reg == ST_TEST) begin
            if (is_read_reg) begin
                res_char_reg <= glyph_char(rd_glyph);
            end else if (d_q > rd_depth) begin
                res_plot_reg <= 1'b1;
            end
        end
        if (state_reg == ST_OUT && (!m_tvalid_reg || m_tready)) begin
            out_char_reg <= res_char_reg;
            out_plot_reg <= res_plot_reg;
        end
    end

    assign rd_depth = ram_rdata[DEPTH_BITS-1:0];
    assign rd_glyph = ram_rdata[DEPTH_BITS +: GLYPH_W];

    // Reads and the clearing pass store a blank cell at zero depth.
    always_comb begin
        ram_we    = (state_reg == ST_CLEAR) ||
                    ((state_reg == ST_TEST) && (is_read_reg || d_q > rd_depth));
        ram_waddr = (state_reg == ST_CLEAR) ? clr_reg : addr_reg;
        if (state_reg == ST_CLEAR || is_read_reg) begin
            ram_wdata = {BLANK_CODE, {DEPTH_BITS{1'b0}}};
        end else begin
            ram_wdata = {n_reg, d_q};
        end
    end

    tpz_ram #(.WIDTH(RAMW), .DEPTH(CELL_COUNT)) u_cells (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (addr_reg),
        .rdata (ram_rdata)
    );

endmodule

[rtl/tpz_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tpz_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/tpz_mul.sv]
// Shared signed multiplier with a registered product and its Q14 quotient
// truncated toward zero. Depends on tpz_pkg.
module tpz_mul #(
    parameter int WIDTH = 20
) (
    input  logic                                       aclk,
    input  logic signed [WIDTH-1:0]                    op_a,
    input  logic signed [WIDTH-1:0]                    op_b,
    output logic signed [2*WIDTH-1:0]                  prod,
    output logic signed [2*WIDTH-tpz_pkg::Q_FRAC-1:0]  prod_q
);
    import tpz_pkg::*;

    localparam int PW = 2*WIDTH;

    logic signed [PW-1:0] prod_reg;
    logic signed [PW-1:0] bias;
    logic signed [PW-1:0] biased;

    always_ff @(posedge aclk) begin
        prod_reg <= op_a * op_b;
    end

    // Negative products are biased so that the arithmetic shift rounds toward zero.
    always_comb begin
        bias   = prod_reg[PW-1] ? PW'(Q_ONE - 1) : '0;
        biased = prod_reg + bias;
    end

    assign prod   = prod_reg;
    assign prod_q = (PW-Q_FRAC)'(biased >>> Q_FRAC);

endmodule

[rtl/tpz_div.sv]
// Restoring divider for the reciprocal depth 2^(14+DEPTH_BITS)/den, one
// quotient bit a cycle, saturating. Depends on tpz_pkg.
module tpz_div #(
    parameter int DEPTH_BITS = 16,
    parameter int DEN_W      = 20
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [DEN_W-1:0]      den,
    output logic                  done,
    output logic [DEPTH_BITS-1:0] quo
);
    import tpz_pkg::*;

    localparam int NB = DEPTH_BITS + Q_FRAC + 1;
    localparam int CW = $clog2(NB + 1);

    logic                  busy_reg;
    logic                  done_reg;
    logic [CW-1:0]         cnt_reg;
    logic [DEN_W-1:0]      den_reg;
    logic [DEN_W-1:0]      rem_reg;
    logic [DEPTH_BITS-1:0] q_reg;
    logic                  sat_reg;
    logic [DEN_W:0]        rem_sh;
    logic                  ge;

    // The numerator is a single one at its top bit.
    always_comb begin
        rem_sh = {rem_reg, (cnt_reg == CW'(NB - 1))};
        ge     = (rem_sh >= {1'b0, den_reg});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else if (start) begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end else if (busy_reg && cnt_reg == '0) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            cnt_reg <= CW'(NB - 1);
            den_reg <= den;
            rem_reg <= '0;
            q_reg   <= '0;
            sat_reg <= 1'b0;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - 1'b1;
            rem_reg <= ge ? DEN_W'(rem_sh - {1'b0, den_reg}) : DEN_W'(rem_sh);
            q_reg   <= {q_reg[DEPTH_BITS-2:0], ge};
            sat_reg <= sat_reg | q_reg[DEPTH_BITS-1];
        end
    end

    assign done = done_reg;
    assign quo  = sat_reg ? '1 : q_reg;

endmodule

[rtl/tpz_checker.sv]
// Port-level checks for the torus point z-buffer shader, bound to its top level.
// Depends on tpz_pkg and torus_point_zbuffer_shader.
module tpz_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [tpz_pkg::OUT_DATA_W-1:0]  m_tdata,
    input logic                            m_tuser
);
    import tpz_pkg::*;

    // Reset empties the output register.
    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result still valid after reset");

    // One item at a time: the block is busy right after a transaction.
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted on consecutive cycles");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // A written plot always reports a space as its glyph.
    a_plot_space: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata[CHAR_W-1:0] == CHAR_SPACE)
        else $error("plotted result carries a glyph");

    a_printable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[CHAR_W-1:0] >= CHAR_SPACE && m_tdata[CHAR_W-1:0] <= CHAR_LAST
                     && m_tdata[OUT_DATA_W-1] == 1'b0)
        else $error("result glyph is not printable");

endmodule

bind torus_point_zbuffer_shader tpz_checker u_tpz_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

[tb/sv/testbench.sv]
// Self-checking testbench for torus_point_zbuffer_shader: plot and read transactions
// are predicted by a fixed-point torus renderer model kept here. Depends on tpz_pkg.
`timescale 1ns / 100ps

module testbench;
    import tpz_pkg::*;

    localparam int COLS  = 80;
    localparam int ROWS  = 22;
    localparam int CELLS = COLS * ROWS;
    localparam int IN_W  = 40;

    typedef struct packed {
        logic [CHAR_W-1:0] cell_char;
        logic              plotted;
    } shade_res_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [IN_W-1:0] s_tdata = '0;
    logic s_tuser = 1'b0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic m_tuser;
    logic cfg_we = 1'b0;
    logic [0:0] cfg_addr = '0;
    logic [11:0] cfg_wdata = '0;

    torus_point_zbuffer_shader u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    // Model state.
    logic [11:0] angle_a, angle_b;
    logic [15:0] depth_mem [CELLS];
    logic [3:0]  glyph_mem [CELLS];
    shade_res_t  shade_q [$];
    int errors = 0;
    bit quiet = 1'b0;

    function automatic longint quarter_sin(longint u);
        longint u2, t;
        u2 = (u * u) >>> 14;
        t = (1160 * u2) >>> 14;
        t = 10512 - t;
        t = (t * u2) >>> 14;
        t = 25736 - t;
        return (t * u) >>> 14;
    endfunction

    function automatic longint sin_q(logic [11:0] code);
        logic [15:0] p;
        longint s;
        p = {code, 4'b0};
        s = p[14] ? quarter_sin(16384 - p[13:0]) : quarter_sin(p[13:0]);
        return p[15] ? -s : s;
    endfunction

    function automatic longint cos_q(logic [11:0] code);
        return sin_q(code + 12'd1024);
    endfunction

    // Truncating Q14 product; SystemVerilog division truncates toward zero.
    function automatic longint qmul(longint a, longint b);
        return (a * b) / 16384;
    endfunction

    function automatic shade_res_t shade_point(logic [11:0] th, logic [11:0] ph);
        longint si, ci, sj, cj, sa, ca, sb, cb, h, ch, lh, cd, t, den, bx, by, lum, n;
        longint d, scale, xs, ys, o;
        shade_res_t r;
        r.cell_char = CHAR_SPACE;
        r.plotted = 1'b0;
        si = sin_q(th); ci = cos_q(th); sj = sin_q(ph); cj = cos_q(ph);
        sa = sin_q(angle_a); ca = cos_q(angle_a); sb = sin_q(angle_b); cb = cos_q(angle_b);
        h = cj + 2 * 16384;
        ch = qmul(si, h);
        den = qmul(ch, sa) + qmul(sj, ca) + 5 * 16384;
        if (den < 1) den = 1;
        d = (longint'(1) << 30) / den;
        if (d > 65535) d = 65535;
        t = qmul(ch, ca) - qmul(sj, sa);
        lh = qmul(ci, h);
        bx = qmul(lh, cb) - qmul(t, sb);
        by = qmul(lh, sb) + qmul(t, cb);
        scale = longint'(1) << 30;
        xs = (40 * scale + 30 * d * bx) / scale;
        ys = (12 * scale + 15 * d * by) / scale;
        cd = qmul(si, cj);
        lum = qmul(qmul(sj, sa) - qmul(cd, ca), cb) - qmul(cd, sa) - qmul(sj, ca)
            - qmul(qmul(ci, cj), sb);
        n = (8 * lum) / 16384;
        if (n < 0) n = 0;
        if (n > 11) n = 11;
        if (ys < ROWS && ys > 0 && xs > 0 && xs < COLS) begin
            o = xs + COLS * ys;
            if (o < CELLS && d > depth_mem[o]) begin
                depth_mem[o] = d[15:0];
                glyph_mem[o] = n[3:0];
                r.plotted = 1'b1;
            end
        end
        return r;
    endfunction

    function automatic shade_res_t read_cell(logic [10:0] addr);
        shade_res_t r;
        r.cell_char = CHAR_SPACE;
        r.plotted = 1'b0;
        if (addr < CELLS) begin
            r.cell_char = glyph_char(glyph_mem[addr]);
            glyph_mem[addr] = BLANK_CODE;
            depth_mem[addr] = '0;
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        errors++;
    endtask

    task automatic write_reg(logic [0:0] idx, logic [11:0] val);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (idx == CFG_ROT_A) angle_a = val; else angle_b = val;
    endtask

    // The valid line stays up after a transaction; the next item, an idle gap or a
    // drain takes it over in the same time step.
    task automatic send_item(logic req, logic [11:0] th, logic [11:0] ph, logic [10:0] addr);
        int gap;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 4);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= req;
        s_tdata <= {5'b0, addr, ph, th};
        do @(posedge aclk); while (!s_tready);
        shade_q.push_back(req == REQ_READ ? read_cell(addr) : shade_point(th, ph));
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (shade_q.size() != 0) @(posedge aclk);
        repeat (150) @(posedge aclk);
    endtask

    // Result side: random back-pressure bursts and the field checks.
    initial begin
        shade_res_t want;
        int stall;
        forever begin
            @(posedge aclk);
            if (m_tvalid && m_tready) begin
                if (shade_q.size() == 0) begin
                    report_mismatch("unexpected result", m_tdata, 0);
                end else begin
                    want = shade_q.pop_front();
                    if (m_tdata[CHAR_W-1:0] !== want.cell_char)
                        report_mismatch("cell_char", m_tdata[CHAR_W-1:0], want.cell_char);
                    if (m_tdata[OUT_DATA_W-1:CHAR_W] !== '0)
                        report_mismatch("tdata pad", m_tdata[OUT_DATA_W-1:CHAR_W], 0);
                    if (m_tuser !== want.plotted)
                        report_mismatch("plotted", m_tuser, want.plotted);
                end
            end
            if (!quiet && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                stall = $urandom_range(1, 4);
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
        end
    end

    task automatic read_all_cells();
        for (int k = 0; k < CELLS; k += 1 + 8 * (k % 3))
            send_item(REQ_READ, 12'($urandom), 12'($urandom), k[10:0]);
    endtask

    task automatic test_directed();
        send_item(REQ_READ, 12'h000, 12'h000, 11'd0);
        send_item(REQ_READ, 12'hFFF, 12'hFFF, 11'd1759);
        send_item(REQ_READ, 12'h000, 12'h000, 11'd1760);
        send_item(REQ_READ, 12'h000, 12'h000, 11'h7FF);
        send_item(REQ_PLOT, 12'h000, 12'h000, 11'd0);
        send_item(REQ_PLOT, 12'hFFF, 12'hFFF, 11'h7FF);
        send_item(REQ_PLOT, 12'd1024, 12'd0, 11'd0);
        send_item(REQ_PLOT, 12'd2048, 12'd3072, 11'd0);
        // Repeating a point gives equal depth, which must not overwrite.
        send_item(REQ_PLOT, 12'd300, 12'd700, 11'd0);
        send_item(REQ_PLOT, 12'd300, 12'd700, 11'd0);
        send_item(REQ_PLOT, 12'd3000, 12'd100, 11'd0);
        drain();
    endtask

    task automatic test_frame(logic [11:0] ra, logic [11:0] rb, int points);
        write_reg(CFG_ROT_A, ra);
        write_reg(CFG_ROT_B, rb);
        for (int i = 0; i < points; i++) begin
            if ($urandom_range(0, 4) == 0)
                send_item(REQ_READ, 12'($urandom), 12'($urandom),
                          11'($urandom_range(0, 1800)));
            else
                send_item(REQ_PLOT, 12'($urandom), 12'($urandom), 11'($urandom));
        end
        // Hold off until every result is back, then read the picture out.
        drain();
        read_all_cells();
        drain();
    endtask

    initial begin
        angle_a = '0;
        angle_b = '0;
        for (int k = 0; k < CELLS; k++) begin
            depth_mem[k] = '0;
            glyph_mem[k] = BLANK_CODE;
        end
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        test_directed();
        test_frame(12'd0, 12'd0, 110);
        test_frame(12'hFFF, 12'hFFF, 110);
        test_frame(12'd1024, 12'd2048, 110);
        test_frame(12'($urandom), 12'($urandom), 150);
        quiet = 1'b1;
        test_frame(12'($urandom), 12'($urandom), 110);
        drain();
        if (errors == 0) begin
            $display("[torus_point_zbuffer_shader] OK");
        end else begin
            $display("[torus_point_zbuffer_shader] ERROR");
        end
        $finish;
    end

    initial begin
        #30ms;
        $display("[torus_point_zbuffer_shader] ERROR");
        $finish;
    end

endmodule
